/* design/ptt_pkg.sv */
// Shared types and constants for the pending transaction table.
package ptt_pkg;

    // Default table depth and configuration reset
    localparam int          SLOTS_DEFAULT   = 8;
    localparam logic [31:0] TIMEOUT_DEFAULT = 32'd1000;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int HANDLE_W = 8;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 8;

    // Stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MATCH  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POLL   = 2'd2;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Slot store controls from the sequencer
    typedef struct packed {
        logic rd_en;   // load read registers from the scan address
        logic ins;     // write entry at the compared slot and mark it valid
        logic rem;     // free the compared slot
    } store_ctrl_t;

    // Occupancy after the pending update
    typedef struct packed {
        logic empty;
        logic has_free;
    } occ_t;

endpackage

/* design/ptt_hit_unit.sv */
// Shared per-slot compare unit: free check, id compare, or wrapping age check.
module ptt_hit_unit (
    input  logic [ptt_pkg::REQ_W-1:0]  req_type,
    input  logic                       slot_valid,
    input  logic [ptt_pkg::ID_W-1:0]   trans_id,
    input  logic [ptt_pkg::ID_W-1:0]   slot_id,
    input  logic [ptt_pkg::TIME_W-1:0] now_ms,
    input  logic [ptt_pkg::TIME_W-1:0] slot_time,
    input  logic [ptt_pkg::TIME_W-1:0] timeout_ms,
    output logic                       hit
);

    logic [ptt_pkg::TIME_W-1:0] age;

    // Age wraps modulo 2^32
    assign age = now_ms - slot_time;

    always_comb begin
        case (req_type)
            ptt_pkg::REQ_INSERT: hit = !slot_valid;
            ptt_pkg::REQ_MATCH:  hit = slot_valid && (slot_id == trans_id);
            ptt_pkg::REQ_POLL:   hit = slot_valid && (age >= timeout_ms);
            default:             hit = 1'b0;
        endcase
    end

endmodule

/* design/ptt_slot_store.sv */
// Slot storage: entry memories with a registered read port, valid bits, fill count.
module ptt_slot_store #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int CW    = $clog2(SLOTS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ptt_pkg::store_ctrl_t         ctrl,
    input  logic [IW-1:0]                rd_addr,
    input  logic [IW-1:0]                cmp_addr,
    input  logic [ptt_pkg::HANDLE_W-1:0] wr_handle,
    input  logic [ptt_pkg::ID_W-1:0]     wr_id,
    input  logic [ptt_pkg::TIME_W-1:0]   wr_time,
    output logic [ptt_pkg::HANDLE_W-1:0] rd_handle,
    output logic [ptt_pkg::ID_W-1:0]     rd_id,
    output logic [ptt_pkg::TIME_W-1:0]   rd_time,
    output logic                         cmp_valid,
    output ptt_pkg::occ_t                occ_after
);

    logic [ptt_pkg::HANDLE_W-1:0] handle_mem [SLOTS];
    logic [ptt_pkg::ID_W-1:0]     id_mem     [SLOTS];
    logic [ptt_pkg::TIME_W-1:0]   time_mem   [SLOTS];

    logic [SLOTS-1:0] valid_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    // Entry memories: one write, one registered read
    always_ff @(posedge aclk) begin
        if (ctrl.ins) begin
            handle_mem[cmp_addr] <= wr_handle;
            id_mem[cmp_addr]     <= wr_id;
            time_mem[cmp_addr]   <= wr_time;
        end
        if (ctrl.rd_en) begin
            rd_handle <= handle_mem[rd_addr];
            rd_id     <= id_mem[rd_addr];
            rd_time   <= time_mem[rd_addr];
        end
    end

    // Valid bits and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            if (ctrl.ins) begin
                valid_reg[cmp_addr] <= 1'b1;
            end else if (ctrl.rem) begin
                valid_reg[cmp_addr] <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign cmp_valid          = valid_reg[cmp_addr];
    assign occ_after.empty    = (count_next == '0);
    assign occ_after.has_free = (count_next != CW'(SLOTS));

endmodule

/* design/pending_transaction_table.sv */
// Pending transaction table top level: stream ports, scan sequencer, result register.
//
// A table of SLOTS outstanding request slots. Insert (s_tuser 0) takes the lowest free
// slot and stamps it with now_ms; match (1) frees the lowest valid slot with trans_id;
// poll (2) frees the lowest valid slot whose wrapping age now_ms - stamp is at least
// timeout_ms; code 3 changes nothing. One transaction is handled at a time. A single
// compare unit checks one slot per cycle behind the registered read port of the slot
// memories; a request ends at its first hit or once all SLOTS slots are checked. The
// result sits in an output register, so the next request is taken while it waits. The
// user must write timeout_ms through the cfg port only while no request is in flight
// (the block does not enforce this); timeout_ms resets to 1000.
module pending_transaction_table #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ptt_pkg::S_TDATA_W-1:0] s_tdata,  // handle_in, trans_id, now_ms
    input  logic [ptt_pkg::REQ_W-1:0]     s_tuser,  // req_type
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,  // slot, handle_out, id_out,
                                                    // table_empty, table_has_free, 0 pad
    output logic [0:0]                    m_tuser,  // ok
    // Configuration: timeout_ms
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ptt_pkg::TIME_W-1:0]    cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    ptt_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                idx_reg, idx_next;
    logic [IW-1:0]                cmp_idx_reg, cmp_idx_next;
    logic                         pend_reg, pend_next;
    logic [ptt_pkg::REQ_W-1:0]    req_reg;
    logic [ptt_pkg::HANDLE_W-1:0] handle_reg;
    logic [ptt_pkg::ID_W-1:0]     tid_reg;
    logic [ptt_pkg::TIME_W-1:0]   now_reg;
    logic [ptt_pkg::TIME_W-1:0]   timeout_reg;

    logic                         out_valid_reg, out_valid_next;
    logic                         ok_reg;
    logic [ptt_pkg::SLOT_W-1:0]   slot_reg;
    logic [ptt_pkg::HANDLE_W-1:0] hout_reg;
    logic [ptt_pkg::ID_W-1:0]     idout_reg;
    ptt_pkg::occ_t                occ_reg;

    ptt_pkg::store_ctrl_t         ctrl;
    ptt_pkg::occ_t                occ_after;
    logic [ptt_pkg::HANDLE_W-1:0] rd_handle;
    logic [ptt_pkg::ID_W-1:0]     rd_id;
    logic [ptt_pkg::TIME_W-1:0]   rd_time;
    logic                         cmp_valid;
    logic                         hit;

    logic accept, at_end, finish, out_free, commit, removing;

    // Slot storage and the shared compare unit
    ptt_slot_store #(
        .SLOTS (SLOTS),
        .IW    (IW),
        .CW    (CW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .rd_addr   (idx_reg[IW-1:0]),
        .cmp_addr  (cmp_idx_reg),
        .wr_handle (handle_reg),
        .wr_id     (tid_reg),
        .wr_time   (now_reg),
        .rd_handle (rd_handle),
        .rd_id     (rd_id),
        .rd_time   (rd_time),
        .cmp_valid (cmp_valid),
        .occ_after (occ_after)
    );

    ptt_hit_unit u_hit (
        .req_type   (req_reg),
        .slot_valid (cmp_valid),
        .trans_id   (tid_reg),
        .slot_id    (rd_id),
        .now_ms     (now_reg),
        .slot_time  (rd_time),
        .timeout_ms (timeout_reg),
        .hit        (hit)
    );

    // Handshake terms
    assign s_tready  = (state_reg == ptt_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign at_end    = (idx_reg == CW'(SLOTS));
    assign finish    = (state_reg == ptt_pkg::ST_SCAN) && pend_reg && (hit || at_end);
    assign out_free  = !out_valid_reg || m_tready;
    assign commit    = finish && out_free;
    assign removing  = (req_reg == ptt_pkg::REQ_MATCH) || (req_reg == ptt_pkg::REQ_POLL);

    // Store controls
    always_comb begin
        ctrl.rd_en = (state_reg == ptt_pkg::ST_SCAN) && !finish && !at_end;
        ctrl.ins   = commit && hit && (req_reg == ptt_pkg::REQ_INSERT);
        ctrl.rem   = commit && hit && removing;
    end

    // Sequencer: next state and scan position
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = pend_reg;
        case (state_reg)
            ptt_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = ptt_pkg::ST_SCAN;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                end
            end
            ptt_pkg::ST_SCAN: begin
                if (commit) begin
                    state_next = ptt_pkg::ST_IDLE;
                    pend_next  = 1'b0;
                end else if (!finish && !at_end) begin
                    idx_next     = idx_reg + CW'(1);
                    cmp_idx_next = idx_reg[IW-1:0];
                    pend_next    = 1'b1;
                end
            end
            default: begin
                state_next = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptt_pkg::ST_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg    <= s_tuser;
            handle_reg <= s_tdata[7:0];
            tid_reg    <= s_tdata[23:8];
            now_reg    <= s_tdata[55:24];
        end
    end

    // Timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ptt_pkg::TIMEOUT_DEFAULT;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_data;
        end
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            ok_reg    <= hit;
            slot_reg  <= hit ? ptt_pkg::SLOT_W'(cmp_idx_reg) : '0;
            hout_reg  <= (hit && removing) ? rd_handle : '0;
            idout_reg <= (hit && removing) ? rd_id : '0;
            occ_reg   <= occ_after;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {6'd0, occ_reg.has_free, occ_reg.empty, idout_reg, hout_reg, slot_reg};

`ifndef NO_ASSERTIONS
    // A result appears only after a scan finishes
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ptt_pkg::ST_SCAN))
        else $error("result raised without a finished scan");

    // A failed request reports no slot, handle or id
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |->
            (m_tdata[7:0] == '0) && (m_tdata[15:8] == '0) && (m_tdata[31:16] == '0))
        else $error("failed request carries nonzero fields");

    // An empty table always has a free slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[32] || m_tdata[33]))
        else $error("table reported empty with no free slot");

    // Scan pointer stays within the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptt_pkg::ST_SCAN) |-> (idx_reg <= CW'(SLOTS)))
        else $error("scan pointer past end of table");

    // Insert and remove never happen together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.ins && ctrl.rem))
        else $error("insert and remove in one cycle");
`endif

endmodule
